@@ hdl/bcs_pkg.sv @@
// ----------------------------------------------------------------------------
// bcs_pkg
// Types, constants and elaboration-time tables of the band compressor.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int TAB_ADDR_BITS = 10;
  localparam int TAB_SIZE      = (1 << TAB_ADDR_BITS) + 1;
  localparam int TAB_SHIFT     = 31 - TAB_ADDR_BITS;

  localparam logic [30:0] UNITY_G   = 31'h4000_0000;
  localparam logic [24:0] COEF_ONE  = 25'h100_0000;
  localparam logic [26:0] DB_K      = 27'd101008905;
  localparam logic [21:0] OCT_K     = 22'd2786635;
  localparam logic [17:0] TANH_K    = 18'd189097;
  localparam logic [4:0]  ENV_EPS   = 5'd21;
  localparam logic signed [18:0] DB_FLOOR = -19'sd30720;

  typedef enum logic [2:0] {
    REG_THRESHOLD, REG_SLOPE, REG_ATTACK, REG_RELEASE,
    REG_BAND_GAIN, REG_DRIVE, REG_BLEND, REG_ASYM
  } reg_addr_t;

  typedef enum logic [5:0] {
    S_IDLE, S_ENV_M1, S_ENV_M2, S_ENV_SUM, S_NORM, S_SQ_M, S_SQ_A,
    S_DB_M, S_DB_A, S_GR_M, S_GR_A, S_OCT_M, S_OCT_A, S_EXP_M, S_EXP_A,
    S_SHIFT, S_SG_M1, S_SG_M2, S_SG_SUM, S_CH_M1, S_CH_A1, S_CH_M2,
    S_CH_A2, S_CH_M3, S_CH_A3, S_CH_M4, S_CH_A4, S_CH_M5, S_CH_A5,
    S_TAB0, S_TAB1, S_TAB2, S_CH_M6, S_CH_A6, S_BLEND_D, S_CH_M7,
    S_CH_A7, S_CH_OUT, S_FIN
  } state_t;

  typedef logic [30:0] root_arr_t [16];
  typedef logic [30:0] tanh_arr_t [TAB_SIZE];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    int i;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic root_arr_t calc_roots();
    root_arr_t t;
    logic [63:0] v;
    int i;
    v = isqrt64(64'd1 << 61);
    t[0] = v[30:0];
    for (i = 1; i < 16; i++) begin
      v = isqrt64(v << 30);
      t[i] = v[30:0];
    end
    return t;
  endfunction

  localparam root_arr_t ROOT_TAB = calc_roots();

  function automatic logic [63:0] pow2_neg_c(input logic [63:0] a);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] g;
    logic [63:0] r;
    logic [63:0] sh;
    int i;
    n = a >> 16;
    f = a & 64'hFFFF;
    r = 64'h4000_0000;
    if (f == 64'd0) begin
      sh = n;
    end else begin
      g = 64'd65536 - f;
      for (i = 0; i < 16; i++) begin
        if (g[15 - i]) begin
          r = (r * {33'd0, ROOT_TAB[i]} + 64'h2000_0000) >> 30;
        end
      end
      sh = n + 64'd1;
    end
    if (sh >= 64'd62) begin
      return 64'd0;
    end
    if (sh == 64'd0) begin
      return r;
    end
    return (r + (64'd1 << (sh - 64'd1))) >> sh;
  endfunction

  function automatic tanh_arr_t calc_tanh();
    tanh_arr_t t;
    logic [63:0] yq;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    logic [64:0] rm;
    int i;
    int j;
    for (i = 0; i < TAB_SIZE; i++) begin
      yq  = 64'(i) << (19 - TAB_ADDR_BITS);
      a   = (yq * 64'(TANH_K) + 64'h8000) >> 16;
      e   = pow2_neg_c(a);
      den = 64'h4000_0000 + e;
      num = ((64'h4000_0000 - e) << 30) + (den >> 1);
      q   = 64'd0;
      rm  = 65'd0;
      for (j = 63; j >= 0; j--) begin
        rm = {rm[63:0], num[j]};
        if (rm >= {1'b0, den}) begin
          rm   = rm - {1'b0, den};
          q[j] = 1'b1;
        end
      end
      t[i] = q[30:0];
    end
    return t;
  endfunction

  localparam tanh_arr_t TANH_TAB = calc_tanh();

endpackage

@@ hdl/band_compressor_saturator.sv @@
// ----------------------------------------------------------------------------
// band_compressor_saturator
// Peak compressor and tanh saturation blend for one stereo band frame.
// ----------------------------------------------------------------------------
// Input words on s_* carry one stereo frame; output words on m_* carry the
// left and right deltas (processed minus original) and the gain reduction.
// Registers are to be written over the APB port only while the block is
// idle; the block itself does not enforce this. Every product runs through
// a single shared multiplier whose product is registered. The 16-step log2
// squaring loop and, when the target gain has a fractional octave, the
// 16-step 2^x product loop dominate; the per-channel path runs once per
// channel. s_tready is high only while the sequencer is idle.
// The result sits in an output register: the next frame is accepted while
// it waits, and the sequencer holds in its final step if the receiver still
// stalls on the previous word. Reset restores the register defaults, clears
// the envelope, sets the smoothed gain to unity and empties the output.
// ----------------------------------------------------------------------------
module band_compressor_saturator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // left_sample[23:0], right_sample[47:24]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // left_delta[23:0], right_delta[47:24],
                                 // reduction_db[62:48], zero[63]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcs_pkg::*;

  state_t state, state_next;

  logic [14:0] threshold_db;
  logic [15:0] comp_slope;
  logic [23:0] attack_coeff;
  logic [23:0] release_coeff;
  logic [18:0] band_gain;
  logic [18:0] sat_drive;
  logic [15:0] sat_blend;
  logic [15:0] sat_asym;

  logic [31:0] envelope;
  logic [30:0] smooth_gain;

  logic [23:0] x_left, x_right;
  logic [31:0] det;
  logic [23:0] coef;
  logic [55:0] acc;
  logic [35:0] mul_a;
  logic [31:0] mul_b;
  logic [67:0] prod;

  logic [31:0] norm;
  logic [4:0]  pos;
  logic [3:0]  cnt;
  logic [30:0] m_sq;
  logic [15:0] frac;
  logic [16:0] over;
  logic [14:0] gr;
  logic [15:0] exp_g;
  logic [30:0] mant;
  logic [4:0]  shamt;
  logic [30:0] tgt;

  logic        ch;
  logic [31:0] s_val;
  logic [33:0] sq_q;
  logic [34:0] b_val;
  logic        y_big;
  logic [9:0]  tab_idx;
  logic [20:0] tab_rem;
  logic [10:0] rom_addr;
  logic [30:0] rom_data;
  logic [30:0] t0;
  logic [30:0] t_val;
  logic        i_neg;
  logic [30:0] i_mag;
  logic        bl_neg;
  logic [31:0] bl_mag;
  logic [31:0] o_val;
  logic [23:0] d_left, d_right;

  logic        accept;
  logic        cfg_wr;
  logic        out_load;
  logic [23:0] mag_l, mag_r, mag_max;
  logic [31:0] det_in;
  logic [23:0] xc, magc;
  logic [56:0] env_sum;
  logic [31:0] env_new;
  logic [31:0] norm_k;
  logic [4:0]  pos_k;
  logic [31:0] sq_w;
  logic [20:0] lg_mag;
  logic [49:0] db_rnd;
  logic signed [18:0] db_s, db_f;
  logic signed [19:0] over_s;
  logic [34:0] gr_rnd;
  logic [38:0] oct_rnd;
  logic [62:0] exp_rnd;
  logic [31:0] rnd_bit, tgt_w;
  logic [60:0] ch1_rnd;
  logic [48:0] ch2_rnd;
  logic [50:0] ch4_rnd;
  logic [54:0] ch5_rnd;
  logic [52:0] im_rnd;
  logic [31:0] t_inc;
  logic [29:0] shaped;
  logic [48:0] bl_rnd;
  logic [33:0] o_w;
  logic [32:0] pm_sum;
  logic signed [28:0] proc_v, delta_v;
  logic [23:0] delta_sat;

  assign accept   = s_tvalid && s_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);
  assign pready   = 1'b1;

  always_comb begin
    case (reg_addr_t'(paddr[4:2]))
      REG_THRESHOLD: prdata = {17'd0, threshold_db};
      REG_SLOPE:     prdata = {16'd0, comp_slope};
      REG_ATTACK:    prdata = {8'd0, attack_coeff};
      REG_RELEASE:   prdata = {8'd0, release_coeff};
      REG_BAND_GAIN: prdata = {13'd0, band_gain};
      REG_DRIVE:     prdata = {13'd0, sat_drive};
      REG_BLEND:     prdata = {16'd0, sat_blend};
      REG_ASYM:      prdata = {16'd0, sat_asym};
      default:       prdata = 32'd0;
    endcase
  end

  // Datapath arithmetic around the shared multiplier
  always_comb begin
    mag_l   = s_tdata[23] ? (~s_tdata[23:0] + 24'd1) : s_tdata[23:0];
    mag_r   = s_tdata[47] ? (~s_tdata[47:24] + 24'd1) : s_tdata[47:24];
    mag_max = (mag_r > mag_l) ? mag_r : mag_l;
    det_in  = {mag_max, 8'd0};

    xc   = ch ? x_right : x_left;
    magc = xc[23] ? (~xc + 24'd1) : xc;

    env_sum = {1'b0, acc} + {1'b0, prod[55:0]} + 57'h80_0000;
    env_new = env_sum[55:24];

    norm_k = norm;
    pos_k  = pos;
    case (cnt[2:0])
      3'd0: if (norm[31:16] == 16'd0) begin
        norm_k = {norm[15:0], 16'd0};
        pos_k  = pos - 5'd16;
      end
      3'd1: if (norm[31:24] == 8'd0) begin
        norm_k = {norm[23:0], 8'd0};
        pos_k  = pos - 5'd8;
      end
      3'd2: if (norm[31:28] == 4'd0) begin
        norm_k = {norm[27:0], 4'd0};
        pos_k  = pos - 5'd4;
      end
      3'd3: if (norm[31:30] == 2'd0) begin
        norm_k = {norm[29:0], 2'd0};
        pos_k  = pos - 5'd2;
      end
      3'd4: if (!norm[31]) begin
        norm_k = {norm[30:0], 1'b0};
        pos_k  = pos - 5'd1;
      end
      default: ;
    endcase

    sq_w   = prod[61:30];
    lg_mag = (pos == 5'd31) ? {5'd0, frac} : ({5'd31 - pos, 16'd0} - {5'd0, frac});

    db_rnd = {1'b0, prod[48:0]} + 50'h8000_0000;
    db_s   = (pos != 5'd31) ? -$signed({2'b00, db_rnd[48:32]})
                            : $signed({2'b00, db_rnd[48:32]});
    db_f   = (db_s < DB_FLOOR) ? DB_FLOOR : db_s;
    over_s = $signed({db_f[18], db_f}) - $signed({{5{threshold_db[14]}}, threshold_db});

    gr_rnd  = {1'b0, prod[33:0]} + 35'h8000;
    oct_rnd = {1'b0, prod[37:0]} + 39'h8000;
    exp_rnd = {1'b0, prod[61:0]} + 63'h2000_0000;

    rnd_bit = (shamt == 5'd0) ? 32'd0 : (32'd1 << (shamt - 5'd1));
    tgt_w   = ({1'b0, mant} + rnd_bit) >> shamt;

    ch1_rnd = {1'b0, prod[59:0]} + 61'h2000_0000;
    ch2_rnd = {1'b0, prod[47:0]} + 49'h8000;
    ch4_rnd = {1'b0, prod[49:0]} + 51'h8000;
    ch5_rnd = {1'b0, prod[53:0]} + 55'h8000;
    im_rnd  = {1'b0, prod[51:0]} + 53'h10_0000;
    t_inc   = i_neg ? ({1'b0, t0} - im_rnd[52:21]) : ({1'b0, t0} + im_rnd[52:21]);

    shaped = 30'(({1'b0, t_val} + 32'd2) >> 2);
    bl_rnd = {1'b0, prod[47:0]} + 49'h8000;
    o_w    = bl_neg ? ({2'b00, s_val} - {1'b0, bl_rnd[48:16]})
                    : ({2'b00, s_val} + {1'b0, bl_rnd[48:16]});

    pm_sum  = {1'b0, o_val} + 33'd16;
    proc_v  = xc[23] ? -$signed({1'b0, pm_sum[32:5]}) : $signed({1'b0, pm_sum[32:5]});
    delta_v = proc_v - $signed({{5{xc[23]}}, xc});
    if (delta_v > 29'sd8388607) begin
      delta_sat = 24'h7F_FFFF;
    end else if (delta_v < -29'sd8388608) begin
      delta_sat = 24'h80_0000;
    end else begin
      delta_sat = delta_v[23:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (s_tvalid) state_next = S_ENV_M1;
      S_ENV_M1:  state_next = S_ENV_M2;
      S_ENV_M2:  state_next = S_ENV_SUM;
      S_ENV_SUM: state_next = S_NORM;
      S_NORM:    if (cnt == 4'd4) state_next = S_SQ_M;
      S_SQ_M:    state_next = S_SQ_A;
      S_SQ_A:    state_next = (cnt == 4'd15) ? S_DB_M : S_SQ_M;
      S_DB_M:    state_next = S_DB_A;
      S_DB_A:    state_next = S_GR_M;
      S_GR_M:    state_next = S_GR_A;
      S_GR_A:    state_next = S_OCT_M;
      S_OCT_M:   state_next = S_OCT_A;
      S_OCT_A:   state_next = (oct_rnd[31:16] == 16'd0) ? S_SHIFT : S_EXP_M;
      S_EXP_M:   state_next = S_EXP_A;
      S_EXP_A:   state_next = (cnt == 4'd15) ? S_SHIFT : S_EXP_M;
      S_SHIFT:   state_next = S_SG_M1;
      S_SG_M1:   state_next = S_SG_M2;
      S_SG_M2:   state_next = S_SG_SUM;
      S_SG_SUM:  state_next = S_CH_M1;
      S_CH_M1:   state_next = S_CH_A1;
      S_CH_A1:   state_next = S_CH_M2;
      S_CH_M2:   state_next = S_CH_A2;
      S_CH_A2:   state_next = S_CH_M3;
      S_CH_M3:   state_next = S_CH_A3;
      S_CH_A3:   state_next = S_CH_M4;
      S_CH_M4:   state_next = S_CH_A4;
      S_CH_A4:   state_next = S_CH_M5;
      S_CH_M5:   state_next = S_CH_A5;
      S_CH_A5:   state_next = S_TAB0;
      S_TAB0:    state_next = S_TAB1;
      S_TAB1:    state_next = S_TAB2;
      S_TAB2:    state_next = y_big ? S_BLEND_D : S_CH_M6;
      S_CH_M6:   state_next = S_CH_A6;
      S_CH_A6:   state_next = S_BLEND_D;
      S_BLEND_D: state_next = S_CH_M7;
      S_CH_M7:   state_next = S_CH_A7;
      S_CH_A7:   state_next = S_CH_OUT;
      S_CH_OUT:  state_next = ch ? S_FIN : S_CH_M1;
      S_FIN:     if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, table address, ready
  always_comb begin
    s_tready = (state == S_IDLE);
    mul_a    = 36'd0;
    mul_b    = 32'd0;
    rom_addr = {1'b0, tab_idx};
    case (state)
      S_ENV_M1: begin mul_a = 36'(coef);            mul_b = envelope; end
      S_ENV_M2: begin mul_a = 36'(COEF_ONE - {1'b0, coef}); mul_b = det; end
      S_SQ_M:   begin mul_a = 36'(m_sq);            mul_b = 32'(m_sq); end
      S_DB_M:   begin mul_a = 36'(lg_mag);          mul_b = 32'(DB_K); end
      S_GR_M:   begin mul_a = 36'(over);            mul_b = 32'(comp_slope); end
      S_OCT_M:  begin mul_a = 36'(gr);              mul_b = 32'(OCT_K); end
      S_EXP_M:  begin mul_a = 36'(mant);            mul_b = 32'(ROOT_TAB[cnt]); end
      S_SG_M1:  begin mul_a = 36'(coef);            mul_b = 32'(smooth_gain); end
      S_SG_M2:  begin mul_a = 36'(COEF_ONE - {1'b0, coef}); mul_b = 32'(tgt); end
      S_CH_M1:  begin mul_a = 36'({magc, 5'd0});    mul_b = 32'(smooth_gain); end
      S_CH_M2:  begin mul_a = 36'(s_val);           mul_b = 32'(band_gain); end
      S_CH_M3:  begin mul_a = 36'(s_val);           mul_b = s_val; end
      S_CH_M4:  begin mul_a = 36'(sq_q);            mul_b = 32'(sat_asym); end
      S_CH_M5:  begin mul_a = 36'(b_val);           mul_b = 32'(sat_drive); end
      S_CH_M6:  begin mul_a = 36'(i_mag);           mul_b = 32'(tab_rem); end
      S_CH_M7:  begin mul_a = 36'(bl_mag);          mul_b = 32'(sat_blend); end
      S_TAB0:   rom_addr = y_big ? 11'(TAB_SIZE - 1) : {1'b0, tab_idx};
      S_TAB1:   rom_addr = {1'b0, tab_idx} + 11'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod     <= {32'd0, mul_a} * {36'd0, mul_b};
    rom_data <= TANH_TAB[rom_addr];
  end

  // Control state, registers and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      threshold_db  <= 15'h7C00;
      comp_slope    <= 16'd0;
      attack_coeff  <= 24'd16773000;
      release_coeff <= 24'd16776000;
      band_gain     <= 19'd65536;
      sat_drive     <= 19'd65536;
      sat_blend     <= 16'd0;
      sat_asym      <= 16'd0;
      envelope      <= 32'd0;
      smooth_gain   <= UNITY_G;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr) begin
        case (reg_addr_t'(paddr[4:2]))
          REG_THRESHOLD: threshold_db  <= pwdata[14:0];
          REG_SLOPE:     comp_slope    <= pwdata[15:0];
          REG_ATTACK:    attack_coeff  <= pwdata[23:0];
          REG_RELEASE:   release_coeff <= pwdata[23:0];
          REG_BAND_GAIN: band_gain     <= pwdata[18:0];
          REG_DRIVE:     sat_drive     <= pwdata[18:0];
          REG_BLEND:     sat_blend     <= pwdata[15:0];
          REG_ASYM:      sat_asym      <= pwdata[15:0];
          default: ;
        endcase
      end
      if (state == S_ENV_SUM) begin
        envelope <= env_new;
      end
      if (state == S_SG_SUM) begin
        smooth_gain <= env_sum[54:24];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (accept) begin
        x_left  <= s_tdata[23:0];
        x_right <= s_tdata[47:24];
        det     <= det_in;
        coef    <= (det_in > envelope) ? attack_coeff : release_coeff;
      end
      S_ENV_M2: acc <= prod[55:0];
      S_ENV_SUM: begin
        norm <= env_new + 32'(ENV_EPS);
        pos  <= 5'd31;
        cnt  <= 4'd0;
      end
      S_NORM: begin
        norm <= norm_k;
        pos  <= pos_k;
        if (cnt == 4'd4) begin
          m_sq <= norm_k[31:1];
          frac <= 16'd0;
          cnt  <= 4'd0;
        end else begin
          cnt <= cnt + 4'd1;
        end
      end
      S_SQ_A: begin
        frac <= {frac[14:0], sq_w[31]};
        m_sq <= sq_w[31] ? sq_w[31:1] : sq_w[30:0];
        cnt  <= cnt + 4'd1;
      end
      S_DB_A: over <= over_s[19] ? 17'd0 : over_s[16:0];
      S_GR_A: gr <= (gr_rnd[34:16] > 19'd32767) ? 15'h7FFF : gr_rnd[30:16];
      S_OCT_A: begin
        mant  <= UNITY_G;
        exp_g <= 16'd0 - oct_rnd[31:16];
        cnt   <= 4'd0;
        if (oct_rnd[31:16] == 16'd0) begin
          shamt <= oct_rnd[36:32];
        end else begin
          shamt <= oct_rnd[36:32] + 5'd1;
        end
      end
      S_EXP_A: begin
        if (exp_g[4'd15 - cnt]) begin
          mant <= exp_rnd[60:30];
        end
        cnt <= cnt + 4'd1;
      end
      S_SHIFT: begin
        tgt  <= tgt_w[30:0];
        coef <= (tgt_w[30:0] < smooth_gain) ? attack_coeff : release_coeff;
      end
      S_SG_M2:  acc <= prod[55:0];
      S_SG_SUM: ch <= 1'b0;
      S_CH_A1:  s_val <= {1'b0, ch1_rnd[60:30]};
      S_CH_A2:  s_val <= ch2_rnd[47:16];
      S_CH_A3:  sq_q <= prod[61:28];
      S_CH_A4:  b_val <= {3'd0, s_val} + ch4_rnd[50:16];
      S_CH_A5: begin
        y_big   <= |ch5_rnd[54:47];
        tab_idx <= ch5_rnd[46:37];
        tab_rem <= ch5_rnd[36:16];
      end
      S_TAB1: t0 <= rom_data;
      S_TAB2: begin
        t_val <= t0;
        i_neg <= rom_data < t0;
        i_mag <= (rom_data < t0) ? (t0 - rom_data) : (rom_data - t0);
      end
      S_CH_A6: t_val <= t_inc[30:0];
      S_BLEND_D: begin
        bl_neg <= {2'b00, shaped} < s_val;
        bl_mag <= ({2'b00, shaped} < s_val) ? (s_val - {2'b00, shaped})
                                            : ({2'b00, shaped} - s_val);
      end
      S_CH_A7: o_val <= o_w[31:0];
      S_CH_OUT: begin
        if (ch) begin
          d_right <= delta_sat;
        end else begin
          d_left <= delta_sat;
        end
        ch <= 1'b1;
      end
      S_FIN: if (out_load) m_tdata <= {1'b0, gr, d_right, d_left};
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) accept |=> !s_tready)
    else $error("frame accepted while sequencer busy");
  assert property (@(posedge clk) disable iff (rst) smooth_gain <= UNITY_G)
    else $error("smoothed gain above unity");
  assert property (@(posedge clk) disable iff (rst) envelope <= 32'h8000_0000)
    else $error("envelope above full scale");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ_M && cnt == 4'd0) |-> m_sq[30])
    else $error("log mantissa not normalized");
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FIN))
    else $error("output word raised outside final step");
`endif

endmodule

@@ sim/band_comp_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// band_comp_checker
// Watches the frame, result and register channels of the band compressor,
// computes every result word from its own copy of the envelope, smoothed
// gain and registers, and compares each output word field by field.
// ----------------------------------------------------------------------------
module band_comp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // left_sample[23:0], right_sample[47:24]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // left_delta[23:0], right_delta[47:24],
                                 // reduction_db[62:48], zero[63]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);
  import bcs_pkg::*;

  localparam longint ONE_Q30 = 64'd1 << 30;
  localparam longint ONE_Q24 = 64'd1 << 24;

  longint thr_db, slope, att_c, rel_c, gain_band, drive, blend, asym;
  longint env_q31, gain_q30;
  longint roots [16];
  longint tanh_q30 [TAB_SIZE];
  logic [63:0] delta_q [$];

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round_shift(longint v, int sh);
    longint m;
    if (sh == 0) return v;
    m = (magn(v) + (64'd1 << (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint exp2_neg(longint a);
    longint n, f, mant, sh, g;
    n = a >>> 16;
    f = a & 64'hFFFF;
    mant = ONE_Q30;
    if (f == 0) begin
      sh = n;
    end else begin
      g = 65536 - f;
      for (int i = 0; i < 16; i++)
        if (g[15 - i]) mant = (mant * roots[i] + (64'd1 << 29)) >>> 30;
      sh = n + 1;
    end
    if (sh >= 62) return 0;
    if (sh == 0) return mant;
    return (mant + (64'd1 << (sh - 1))) >>> sh;
  endfunction

  function automatic longint level_db(longint e);
    int p;
    longint m, frac, lg, db;
    p = 63;
    frac = 0;
    while (p > 0 && !e[p]) p--;
    m = p <= 30 ? e << (30 - p) : e >>> (p - 30);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >>> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >>> 1;
      end
    end
    lg = longint'(p - 31) * 65536 + frac;
    db = round_shift(lg * longint'(DB_K), 32);
    return db < -30720 ? -30720 : db;
  endfunction

  function automatic longint tanh_interp(longint y);
    longint idx, rem;
    if (y >= (64'd1 << 31)) return tanh_q30[TAB_SIZE - 1];
    idx = y >>> TAB_SHIFT;
    rem = y & ((64'd1 << TAB_SHIFT) - 1);
    return tanh_q30[idx] +
           round_shift((tanh_q30[idx + 1] - tanh_q30[idx]) * rem, TAB_SHIFT);
  endfunction

  function automatic logic [63:0] compress_frame(logic [47:0] frame);
    longint x [2];
    longint d, c, over, gr, tgt, s, b, y, shaped, o, proc, delta;
    logic [63:0] word;
    x[0] = longint'($signed(frame[23:0]));
    x[1] = longint'($signed(frame[47:24]));
    d = magn(x[0]) > magn(x[1]) ? magn(x[0]) : magn(x[1]);
    d = d << 8;
    c = d > env_q31 ? att_c : rel_c;
    env_q31 = (c * env_q31 + (ONE_Q24 - c) * d + (64'd1 << 23)) >>> 24;
    over = level_db(env_q31 + 21) - thr_db;
    if (over < 0) over = 0;
    gr = (over * slope + 64'h8000) >>> 16;
    if (gr > 32767) gr = 32767;
    tgt = exp2_neg((gr * longint'(OCT_K) + 64'h8000) >>> 16);
    c = tgt < gain_q30 ? att_c : rel_c;
    gain_q30 = (c * gain_q30 + (ONE_Q24 - c) * tgt + (64'd1 << 23)) >>> 24;
    word = '0;
    for (int ch = 0; ch < 2; ch++) begin
      s = magn(x[ch]) << 5;
      s = (s * gain_q30 + (64'd1 << 29)) >>> 30;
      s = (s * gain_band + 64'h8000) >>> 16;
      b = s + (((((s * s) >>> 28) * asym) + 64'h8000) >>> 16);
      y = (b * drive + 64'h8000) >>> 16;
      shaped = (tanh_interp(y) + 2) >>> 2;
      o = s + round_shift((shaped - s) * blend, 16);
      proc = x[ch] < 0 ? -o : o;
      proc = round_shift(proc, 5);
      delta = proc - x[ch];
      if (delta > 8388607) delta = 8388607;
      if (delta < -8388608) delta = -8388608;
      word[24*ch +: 24] = delta[23:0];
    end
    word[62:48] = gr[14:0];
    return word;
  endfunction

  initial begin
    longint yq, a, e, den;
    roots[0] = int_sqrt(64'd1 << 61);
    for (int i = 1; i < 16; i++) roots[i] = int_sqrt(roots[i - 1] << 30);
    for (int i = 0; i < TAB_SIZE; i++) begin
      yq = longint'(i) << (19 - TAB_ADDR_BITS);
      a = (yq * longint'(TANH_K) + 64'h8000) >>> 16;
      e = exp2_neg(a);
      den = ONE_Q30 + e;
      tanh_q30[i] = (((ONE_Q30 - e) << 30) + den / 2) / den;
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (rst) begin
      thr_db = -1024;
      slope = 0;
      att_c = 16773000;
      rel_c = 16776000;
      gain_band = 65536;
      drive = 65536;
      blend = 0;
      asym = 0;
      env_q31 = 0;
      gain_q30 = ONE_Q30;
      delta_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_addr_t'(paddr[4:2]))
          REG_THRESHOLD: thr_db = longint'($signed(pwdata[14:0]));
          REG_SLOPE:     slope = pwdata[15:0];
          REG_ATTACK:    att_c = pwdata[23:0];
          REG_RELEASE:   rel_c = pwdata[23:0];
          REG_BAND_GAIN: gain_band = pwdata[18:0];
          REG_DRIVE:     drive = pwdata[18:0];
          REG_BLEND:     blend = pwdata[15:0];
          REG_ASYM:      asym = pwdata[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (delta_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = delta_q.pop_front();
          if (m_tdata[23:0] !== want[23:0]) begin
            $display("%0t: left_delta expected %h actual %h", $time, want[23:0],
                     m_tdata[23:0]);
            mismatches++;
          end
          if (m_tdata[47:24] !== want[47:24]) begin
            $display("%0t: right_delta expected %h actual %h", $time, want[47:24],
                     m_tdata[47:24]);
            mismatches++;
          end
          if (m_tdata[63:48] !== want[63:48]) begin
            $display("%0t: reduction_db expected %h actual %h", $time,
                     want[63:48], m_tdata[63:48]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) delta_q.insert(delta_q.size(), compress_frame(s_tdata));
    end
    pending = delta_q.size();
  end

endmodule

@@ sim/tb_band_compressor_saturator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_band_compressor_saturator
// Drives stereo frames and register settings into the band compressor with
// random gaps on both streams, a long output stall and drain points, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_band_compressor_saturator;
  import bcs_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // left_sample[23:0], right_sample[47:24]
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // left_delta[23:0], right_delta[47:24],
                          // reduction_db[62:48], zero[63]
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  int  mismatches, pending;
  bit  gaps_on;
  bit  hold_req;
  int  hold_cnt;

  band_compressor_saturator dut (.*);

  band_comp_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, or a long counted hold-off on request
  initial begin
    m_tready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready = 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
        m_tready = 1'b0;
      end else begin
        m_tready = gaps_on ? ($urandom_range(99) >= 35) : 1'b1;
      end
    end
  end

  task automatic reg_write(reg_addr_t r, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic load_regs(logic [31:0] v [8]);
    for (int i = 0; i < 8; i++) reg_write(reg_addr_t'(i), v[i]);
  endtask

  task automatic send_frame(logic [23:0] l, logic [23:0] r);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 35) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {r, l};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(4))
      0: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      1: return 24'($signed($urandom_range(2000)) - 1000);
      2: return 24'($signed($urandom_range(200000)) - 100000);
      default: return 24'($urandom);
    endcase
  endfunction

  logic [31:0] regs [8];
  logic [23:0] edge_vals [8] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                                 24'h000001, 24'h400000, 24'hC00000, 24'h7FFFFF};

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // defaults, extremes and silence
    regs = '{32'h0000_7C00, 0, 16773000, 16776000, 65536, 65536, 0, 0};
    load_regs(regs);
    for (int i = 0; i < 8; i++) send_frame(edge_vals[i], edge_vals[7 - i]);
    repeat (4) send_frame(24'h0, 24'h0);
    drain();

    // hard compression, overflowing deltas, far tanh argument
    regs = '{32'hFFFF_C000, 65535, 0, 0, 524287, 262144, 65535, 65535};
    load_regs(regs);
    for (int i = 0; i < 8; i++) send_frame(edge_vals[i], edge_vals[(i + 3) % 8]);
    drain();

    // all-zero settings, drive below one, upper register bits set
    regs = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFF00_0000, 32'hFF00_0000,
             32'hFFF8_0000, 32'hFFF8_03E8, 32'hFFFF_0000, 32'hFFFF_0000};
    load_regs(regs);
    for (int i = 0; i < 4; i++) send_frame(edge_vals[i], edge_vals[i + 4]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 6) begin
        regs = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      end else begin
        regs[REG_THRESHOLD] = 32'($signed($urandom_range(24576)) - 16384);
        regs[REG_SLOPE]     = $urandom_range(65535);
        regs[REG_ATTACK]    = $urandom_range(1) ? $urandom_range(16777215)
                                                : 16777215 - $urandom_range(50000);
        regs[REG_RELEASE]   = $urandom_range(1) ? $urandom_range(16777215)
                                                : 16777215 - $urandom_range(50000);
        regs[REG_BAND_GAIN] = $urandom_range(524287);
        regs[REG_DRIVE]     = $urandom_range(262144, 65536);
        regs[REG_BLEND]     = $urandom_range(65535);
        regs[REG_ASYM]      = $urandom_range(65535);
        if (ph == 2) regs[REG_ATTACK] = $urandom;
      end
      load_regs(regs);
      gaps_on = (ph != 3);
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < 80; n++) begin
        if ((n / 20) % 2 == 1 && $urandom_range(1))
          send_frame(24'($signed($urandom_range(64)) - 32), pick_sample());
        else
          send_frame(pick_sample(), pick_sample());
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/bcs_pkg.sv
hdl/band_compressor_saturator.sv
sim/band_comp_checker.sv
sim/tb_band_compressor_saturator.sv
